FILE: hdl/sha1c_pkg.sv
`timescale 1ns / 1ps
package sha1c_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;
	typedef logic [2:0] step_t;
	typedef logic [2:0] widx_t;
	typedef logic [2:0] cfg_idx_t;
	typedef logic [6:0] rnd_t;

	localparam int unsigned CHAIN_WORDS = 5;
	localparam widx_t LAST_IDX = 3'd4;
	localparam logic [3:0] LAST_WORD = 4'd15;
	localparam rnd_t LAST_ROUND = 7'd79;

	// register indexes of the configuration port
	localparam cfg_idx_t REG_INIT0 = 3'd0;
	localparam cfg_idx_t REG_INIT1 = 3'd1;
	localparam cfg_idx_t REG_INIT2 = 3'd2;
	localparam cfg_idx_t REG_INIT3 = 3'd3;
	localparam cfg_idx_t REG_INIT4 = 3'd4;

	localparam word_t IV0 = 32'h67452301;
	localparam word_t IV1 = 32'hEFCDAB89;
	localparam word_t IV2 = 32'h98BADCFE;
	localparam word_t IV3 = 32'h10325476;
	localparam word_t IV4 = 32'hC3D2E1F0;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	// program steps
	localparam step_t STEP_LOAD  = 3'd0;
	localparam step_t STEP_SETUP = 3'd1;
	localparam step_t STEP_ROUND = 3'd2;
	localparam step_t STEP_ADD   = 3'd3;
	localparam step_t STEP_EMIT  = 3'd4;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_BLOCK_DONE,
		COND_ROUND_LAST,
		COND_NOT_FINAL,
		COND_EMIT_DONE
	} cond_t;

	// datapath controls
	typedef struct packed {
		logic shift_in;
		logic restart;
		logic load_work;
		logic round_en;
		logic add_en;
	} ctl_t;

	// one control word of the program
	typedef struct packed {
		logic  in_ready;
		logic  load_work;
		logic  round_en;
		logic  add_en;
		logic  emit;
		cond_t cond;
		step_t target;
		logic  advance;
	} uword_t;

	function automatic uword_t ucode(input step_t pc);
		uword_t u;
		u = '{in_ready: 1'b0, load_work: 1'b0, round_en: 1'b0, add_en: 1'b0, emit: 1'b0,
			cond: COND_NONE, target: STEP_LOAD, advance: 1'b0};
		unique case (pc)
			STEP_LOAD: begin
				u.in_ready = 1'b1;
				u.cond = COND_BLOCK_DONE;
				u.target = STEP_SETUP;
			end
			STEP_SETUP: begin
				u.load_work = 1'b1;
				u.advance = 1'b1;
			end
			STEP_ROUND: begin
				u.round_en = 1'b1;
				u.cond = COND_ROUND_LAST;
				u.target = STEP_ADD;
			end
			STEP_ADD: begin
				u.add_en = 1'b1;
				u.cond = COND_NOT_FINAL;
				u.target = STEP_LOAD;
				u.advance = 1'b1;
			end
			STEP_EMIT: begin
				u.emit = 1'b1;
				u.cond = COND_EMIT_DONE;
				u.target = STEP_LOAD;
			end
			default: begin
				u.advance = 1'b0;
			end
		endcase
		return u;
	endfunction

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic word_t round_f(input rnd_t r, input word_t b, input word_t c,
		input word_t d);
		word_t f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r >= 7'd40 && r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic word_t round_k(input rnd_t r);
		word_t k;
		if (r < 7'd20) begin
			k = K0;
		end else if (r < 7'd40) begin
			k = K1;
		end else if (r < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage

FILE: hdl/sha1c_if.sv
`timescale 1ns / 1ps
interface sha1c_msg_if;
	import sha1c_pkg::*;
	logic  valid;
	logic  ready;
	word_t message_word;
	logic  chain_start;
	logic  final_block;
	modport source (output valid, message_word, chain_start, final_block, input ready);
	modport sink (input valid, message_word, chain_start, final_block, output ready);
endinterface

interface sha1c_dig_if;
	import sha1c_pkg::*;
	logic  valid;
	logic  ready;
	word_t digest_word;
	widx_t digest_index;
	logic  digest_last;
	modport source (output valid, digest_word, digest_index, digest_last, input ready);
	modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

FILE: hdl/sha1_block_compressor.sv
`timescale 1ns / 1ps
// channel | dir | payload                                  | word accepted when
// msg     | in  | message_word, chain_start, final_block   | msg.valid && msg.ready
// dig     | out | digest_word, digest_index, digest_last   | dig.valid && dig.ready
// cfg     | in  | cfg_index, cfg_data (init words 0..4)    | cfg_we
//
// A block of sixteen message words is taken at one word per cycle, then the
// sequencer runs a setup step, the 80 rounds (one round per cycle on the
// single round adder) and an add step.
// A final block then offers the five digest words, held while dig.ready is low.
// msg.ready is low from the sixteenth word until the block (and digest) is done.
// Reset restores the standard initial chaining value in both the init registers
// and the chaining value; no clearing pass is needed.
module sha1_block_compressor
	import sha1c_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  cfg_idx_t      cfg_index,
	input  word_t         cfg_data,
	sha1c_msg_if.sink     msg,
	sha1c_dig_if.source   dig
);

	step_t      pc_q;
	logic [3:0] cnt_q;      // words taken in the current block
	logic       final_q;    // final flag of the block being compressed
	widx_t      idx_q;      // digest word being offered
	chain_t     init_q;

	uword_t     uw;
	ctl_t       ctl;
	logic       msg_fire;
	logic       dig_fire;
	logic       block_done;
	logic       round_last;
	logic       cond_hit;
	word_t      out_word;

	// control word of the current step
	assign uw = ucode(pc_q);

	assign msg_fire = msg.valid && msg.ready;
	assign dig_fire = dig.valid && dig.ready;
	// a chain start restarts the count, so that word is never the sixteenth
	assign block_done = msg_fire && !msg.chain_start && (cnt_q == LAST_WORD);

	always_comb begin
		unique case (uw.cond)
			COND_NONE:       cond_hit = 1'b0;
			COND_BLOCK_DONE: cond_hit = block_done;
			COND_ROUND_LAST: cond_hit = round_last;
			COND_NOT_FINAL:  cond_hit = !final_q;
			COND_EMIT_DONE:  cond_hit = dig_fire && (idx_q == LAST_IDX);
			default:         cond_hit = 1'b0;
		endcase
	end

	assign ctl = '{shift_in: msg_fire, restart: msg_fire && msg.chain_start,
		load_work: uw.load_work, round_en: uw.round_en, add_en: uw.add_en};

	assign msg.ready = uw.in_ready;
	assign dig.valid = uw.emit;
	assign dig.digest_word = out_word;
	assign dig.digest_index = idx_q;
	assign dig.digest_last = (idx_q == LAST_IDX);

	sha1c_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.msg_word   (msg.message_word),
		.init_words (init_q),
		.out_idx    (idx_q),
		.round_last (round_last),
		.out_word   (out_word)
	);

	// sequencer: jump on a taken condition, else step on or hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
			cnt_q <= '0;
			final_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cond_hit) begin
				pc_q <= uw.target;
			end else if (uw.advance) begin
				pc_q <= pc_q + 3'd1;
			end
			if (msg_fire) begin
				cnt_q <= msg.chain_start ? 4'd1 : cnt_q + 4'd1;
			end
			if (block_done) begin
				final_q <= msg.final_block;
			end
			if (dig_fire) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 3'd1;
			end
		end
	end

	// init word registers; indexes past the last one are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= {IV4, IV3, IV2, IV1, IV0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INIT0: init_q[0] <= cfg_data;
				REG_INIT1: init_q[1] <= cfg_data;
				REG_INIT2: init_q[2] <= cfg_data;
				REG_INIT3: init_q[3] <= cfg_data;
				REG_INIT4: init_q[4] <= cfg_data;
				default: init_q <= init_q;
			endcase
		end
	end

	// input and output sides never open together
	assert property (@(posedge clk) disable iff (!arst_n) !(msg.ready && dig.valid))
		else $error("input ready while digest offered");

	// the sixteenth word closes the input side
	assert property (@(posedge clk) disable iff (!arst_n) block_done |=> !msg.ready)
		else $error("input still open after a full block");

	// nothing follows the last digest word
	assert property (@(posedge clk) disable iff (!arst_n)
		dig_fire && dig.digest_last |=> !dig.valid && idx_q == '0)
		else $error("digest output ran past the last word");

	// rounds run only with the input closed
	assert property (@(posedge clk) disable iff (!arst_n) uw.round_en |-> !msg.ready)
		else $error("rounds running with input open");

endmodule

FILE: hdl/sha1c_datapath.sv
`timescale 1ns / 1ps
module sha1c_datapath
	import sha1c_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  ctl_t   ctl,
	input  word_t  msg_word,
	input  chain_t init_words,
	input  widx_t  out_idx,
	output logic   round_last,
	output word_t  out_word
);

	// schedule window, oldest word at index 0
	word_t  win_q [16];
	chain_t chain_q;
	word_t  a_q, b_q, c_q, d_q, e_q;
	rnd_t   rnd_q;
	word_t  w_cur;
	word_t  t_sum;

	always_comb begin
		if (rnd_q < 7'd16) begin
			w_cur = win_q[0];
		end else begin
			w_cur = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
		end
		t_sum = rotl(a_q, 5) + round_f(rnd_q, b_q, c_q, d_q) + e_q + round_k(rnd_q) + w_cur;
	end

	assign round_last = (rnd_q == LAST_ROUND);

	always_comb begin
		unique case (out_idx)
			3'd0: out_word = chain_q[0];
			3'd1: out_word = chain_q[1];
			3'd2: out_word = chain_q[2];
			3'd3: out_word = chain_q[3];
			default: out_word = chain_q[4];
		endcase
	end

	// the first sixteen rounds rotate the window once around, later rounds push W[t]
	always_ff @(posedge clk) begin
		if (ctl.shift_in || ctl.round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= ctl.shift_in ? msg_word : w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {IV4, IV3, IV2, IV1, IV0};
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
			rnd_q <= '0;
		end else begin
			if (ctl.restart) begin
				chain_q <= init_words;
			end else if (ctl.add_en) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (ctl.load_work) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
				rnd_q <= '0;
			end else if (ctl.round_en) begin
				a_q <= t_sum;
				b_q <= a_q;
				c_q <= rotl(b_q, 30);
				d_q <= c_q;
				e_q <= d_q;
				rnd_q <= round_last ? '0 : rnd_q + 7'd1;
			end
		end
	end

endmodule
